>>> rtl/core/rhpp_pkg.sv
// rhpp_pkg: shared types and fixed constants of the rtp h264 / pcma packetizer
// holds the command struct passed from the front end to the back end
// depends on nothing
package rhpp_pkg;

  localparam int RTP_HDR_BYTES = 12;
  localparam int FU_BYTES      = 2;
  localparam int EXT_BYTES     = 8;
  localparam int MAX_RESULTS   = 50;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
  localparam logic [4:0] NAL_TYPE_FU_A = 5'd28;

  typedef enum logic [1:0] {
    CFG_SPS_LENGTH = 2'd0,
    CFG_PPS_LENGTH = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_SPS    = 2'd0,
    KIND_PPS    = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_FU_A   = 2'd3
  } kind_t;

  typedef struct packed {
    logic        is_video;
    logic [31:0] ts;
    logic [15:0] size;
    logic [4:0]  nal_type;
    logic [1:0]  nri;
    logic        keyframe;
    logic        audio_ok;
    logic        need_sps;
    logic        need_pps;
    logic        single;
    logic [10:0] sps_len;
    logic [10:0] pps_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/rhpp_front.sv
// rhpp_front: input handshake and classification of one unit into a command
// depends on rhpp_pkg
module rhpp_front #(
  parameter int MAX_PACKET_BYTES = 1400
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [31:0]         timestamp,
  input  logic [15:0]         unit_size,
  input  logic [7:0]          nal_header,
  input  logic [10:0]         sps_length,
  input  logic [10:0]         pps_length,
  input  rhpp_pkg::q_status_t q_status,
  output logic                push,
  output rhpp_pkg::cmd_t      push_data
);

  localparam logic [15:0] SINGLE_MAX =
    16'(MAX_PACKET_BYTES - rhpp_pkg::RTP_HDR_BYTES);
  localparam logic [10:0] SPS_CAP =
    11'(MAX_PACKET_BYTES - rhpp_pkg::RTP_HDR_BYTES - rhpp_pkg::EXT_BYTES);
  localparam logic [10:0] PPS_CAP =
    11'(MAX_PACKET_BYTES - rhpp_pkg::RTP_HDR_BYTES);

  logic kf;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;
  assign kf       = (nal_header[4:0] == rhpp_pkg::NAL_TYPE_IDR);

  always_comb begin
    push_data          = '0;
    push_data.is_video = mode;
    push_data.ts       = timestamp;
    push_data.size     = unit_size;
    push_data.nal_type = nal_header[4:0];
    push_data.nri      = nal_header[6:5];
    push_data.keyframe = kf;
    // audio and single-unit video share the same size limit
    push_data.audio_ok = (unit_size <= SINGLE_MAX);
    push_data.single   = (unit_size <= SINGLE_MAX);
    push_data.need_sps = kf && (sps_length != 11'd0);
    push_data.need_pps = kf && (pps_length != 11'd0);
    push_data.sps_len  = (sps_length > SPS_CAP) ? SPS_CAP : sps_length;
    push_data.pps_len  = (pps_length > PPS_CAP) ? PPS_CAP : pps_length;
  end

endmodule

>>> rtl/core/rhpp_queue.sv
// rhpp_queue: two-entry register queue of commands between front and back
// depends on rhpp_pkg
module rhpp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rhpp_pkg::cmd_t      push_data,
  input  logic                pop,
  output rhpp_pkg::cmd_t      pop_data,
  output rhpp_pkg::q_status_t q_status
);

  rhpp_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign pop_data       = entry[rd_ptr];
  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/rhpp_back.sv
// rhpp_back: packet sequencer, sequence counters and output register
// depends on rhpp_pkg
module rhpp_back #(
  parameter int MAX_PACKET_BYTES = 1400
) (
  input  logic                clk,
  input  logic                rst,
  input  rhpp_pkg::cmd_t      q_data,
  input  rhpp_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                is_video,
  output logic                keyframe,
  output logic [15:0]         seq_num,
  output logic [31:0]         ts_out,
  output logic                marker,
  output logic [1:0]          kind,
  output logic [7:0]          fu_indicator,
  output logic [7:0]          fu_header,
  output logic [15:0]         payload_offset,
  output logic [10:0]         payload_length,
  output logic                last_of_run,
  output logic                status
);

  localparam logic [10:0] FRAG_LEN = 11'(MAX_PACKET_BYTES - rhpp_pkg::RTP_HDR_BYTES
                                         - rhpp_pkg::FU_BYTES);
  localparam int CW = rhpp_pkg::CNT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_AUDIO = 6'b000010,
    ST_SPS   = 6'b000100,
    ST_PPS   = 6'b001000,
    ST_BODY  = 6'b010000,
    ST_FRAG  = 6'b100000
  } state_t;

  state_t         state, state_next;
  rhpp_pkg::cmd_t cmd;
  logic [15:0]    video_seq, video_seq_next;
  logic [15:0]    audio_seq, audio_seq_next;
  logic [15:0]    off, off_next;
  logic [15:0]    rem, rem_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic           fire;
  logic           rem_fits;
  logic [10:0]    frag_n;
  logic [7:0]     fu_ind;

  // descriptor under construction
  logic        d_video, d_kf, d_marker, d_last, d_status;
  logic [15:0] d_seq, d_off;
  logic [1:0]  d_kind;
  logic [7:0]  d_ind, d_hdr;
  logic [10:0] d_len;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign fire     = (state != ST_IDLE) && (!out_valid || !out_stall);
  assign rem_fits = (rem <= {5'd0, FRAG_LEN});
  assign frag_n   = rem_fits ? rem[10:0] : FRAG_LEN;
  assign fu_ind   = {1'b0, cmd.nri, rhpp_pkg::NAL_TYPE_FU_A};

  always_comb begin
    state_next     = state;
    video_seq_next = video_seq;
    audio_seq_next = audio_seq;
    off_next       = off;
    rem_next       = rem;
    cnt_next       = cnt;
    d_video        = 1'b1;
    d_kf           = cmd.keyframe;
    d_seq          = video_seq;
    d_marker       = 1'b0;
    d_kind         = rhpp_pkg::KIND_SINGLE;
    d_ind          = 8'd0;
    d_hdr          = 8'd0;
    d_off          = 16'd0;
    d_len          = 11'd0;
    d_last         = 1'b0;
    d_status       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          cnt_next = '0;
          if (!q_data.is_video)    state_next = ST_AUDIO;
          else if (q_data.need_sps) state_next = ST_SPS;
          else if (q_data.need_pps) state_next = ST_PPS;
          else                      state_next = ST_BODY;
        end
      end
      ST_AUDIO: begin
        d_video  = 1'b0;
        d_kf     = 1'b1;
        d_seq    = audio_seq;
        d_marker = cmd.audio_ok;
        d_len    = cmd.audio_ok ? cmd.size[10:0] : 11'd0;
        d_last   = 1'b1;
        d_status = !cmd.audio_ok;
        if (fire) begin
          if (cmd.audio_ok) audio_seq_next = audio_seq + 16'd1;
          state_next = ST_IDLE;
        end
      end
      ST_SPS: begin
        d_kind = rhpp_pkg::KIND_SPS;
        d_len  = cmd.sps_len;
        if (fire) begin
          video_seq_next = video_seq + 16'd1;
          cnt_next       = cnt + CW'(1);
          state_next     = cmd.need_pps ? ST_PPS : ST_BODY;
        end
      end
      ST_PPS: begin
        d_kind = rhpp_pkg::KIND_PPS;
        d_len  = cmd.pps_len;
        if (fire) begin
          video_seq_next = video_seq + 16'd1;
          cnt_next       = cnt + CW'(1);
          state_next     = ST_BODY;
        end
      end
      ST_BODY: begin
        if (cmd.single) begin
          d_marker = 1'b1;
          d_len    = cmd.size[10:0];
          d_last   = 1'b1;
        end else begin
          // first fragment skips the nal header byte
          d_kind = rhpp_pkg::KIND_FU_A;
          d_ind  = fu_ind;
          d_hdr  = {3'b100, cmd.nal_type};
          d_off  = 16'd1;
          d_len  = FRAG_LEN;
        end
        if (fire) begin
          video_seq_next = video_seq + 16'd1;
          cnt_next       = cnt + CW'(1);
          off_next       = 16'd1 + {5'd0, FRAG_LEN};
          rem_next       = cmd.size - 16'd1 - {5'd0, FRAG_LEN};
          state_next     = cmd.single ? ST_IDLE : ST_FRAG;
        end
      end
      ST_FRAG: begin
        d_kind   = rhpp_pkg::KIND_FU_A;
        d_ind    = fu_ind;
        d_hdr    = {1'b0, rem_fits, 1'b0, cmd.nal_type};
        d_marker = rem_fits;
        d_off    = off;
        d_len    = frag_n;
        // descriptor budget ends the run early on long units
        d_last   = rem_fits || (cnt == CW'(rhpp_pkg::MAX_RESULTS - 1));
        if (fire) begin
          video_seq_next = video_seq + 16'd1;
          cnt_next       = cnt + CW'(1);
          off_next       = off + {5'd0, frag_n};
          rem_next       = rem - {5'd0, frag_n};
          if (d_last) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      video_seq <= 16'd0;
      audio_seq <= 16'd0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      video_seq <= video_seq_next;
      audio_seq <= audio_seq_next;
      cnt       <= cnt_next;
      if (fire)           out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    off <= off_next;
    rem <= rem_next;
    if (pop) cmd <= q_data;
    if (fire) begin
      is_video       <= d_video;
      keyframe       <= d_kf;
      seq_num        <= d_seq;
      ts_out         <= cmd.ts;
      marker         <= d_marker;
      kind           <= d_kind;
      fu_indicator   <= d_ind;
      fu_header      <= d_hdr;
      payload_offset <= d_off;
      payload_length <= d_len;
      last_of_run    <= d_last;
      status         <= d_status;
    end
  end

endmodule

>>> rtl/core/rtp_h264_pcma_packetizer_unit.sv
// rtp_h264_pcma_packetizer_unit: top level of the rtp packet descriptor generator
// depends on rhpp_pkg, rhpp_front, rhpp_queue, rhpp_back

// Each accepted item describes one H.264 NAL unit or one PCMA audio frame;
// the block answers with one descriptor per RTP packet (sequence number,
// marker, kind, FU-A bytes, payload offset and length), last_of_run marking
// the final one. Keyframes get an SPS and a PPS descriptor first when those
// lengths are nonzero; large NALs are cut into FU-A fragments. The front end
// classifies an item in the cycle it is accepted and places it in a
// two-entry command queue, so up to two items are taken while the back end
// is busy. The back end sequencer loads a command while idle and then emits
// one descriptor per cycle into the output register whenever out_stall does
// not hold back a waiting descriptor; a video item gives at most 50 of them.
// There is no memory and no clearing pass; cfg_ready is always high and
// writes go straight to the two length registers.
module rtp_h264_pcma_packetizer_unit #(
  parameter int MAX_PACKET_BYTES = 1400
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] timestamp,
  input  logic [15:0] unit_size,
  input  logic [7:0]  nal_header,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_video,
  output logic        keyframe,
  output logic [15:0] seq_num,
  output logic [31:0] ts_out,
  output logic        marker,
  output logic [1:0]  kind,
  output logic [7:0]  fu_indicator,
  output logic [7:0]  fu_header,
  output logic [15:0] payload_offset,
  output logic [10:0] payload_length,
  output logic        last_of_run,
  output logic        status
);

  logic [10:0]         sps_length;
  logic [10:0]         pps_length;
  logic                push;
  logic                pop;
  rhpp_pkg::cmd_t      push_data;
  rhpp_pkg::cmd_t      pop_data;
  rhpp_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  // register file: indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      sps_length <= 11'd0;
      pps_length <= 11'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rhpp_pkg::CFG_SPS_LENGTH: sps_length <= cfg_data;
        rhpp_pkg::CFG_PPS_LENGTH: pps_length <= cfg_data;
        default: ;
      endcase
    end
  end

  rhpp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .timestamp (timestamp),
    .unit_size (unit_size),
    .nal_header(nal_header),
    .sps_length(sps_length),
    .pps_length(pps_length),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  rhpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_status (q_status)
  );

  rhpp_back #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_data        (pop_data),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_video      (is_video),
    .keyframe      (keyframe),
    .seq_num       (seq_num),
    .ts_out        (ts_out),
    .marker        (marker),
    .kind          (kind),
    .fu_indicator  (fu_indicator),
    .fu_header     (fu_header),
    .payload_offset(payload_offset),
    .payload_length(payload_length),
    .last_of_run   (last_of_run),
    .status        (status)
  );

  // a dropped audio frame is always a lone audio descriptor
  a_status_audio: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !is_video && last_of_run && !marker)
    else $error("status set on a descriptor that is not a lone audio item");

  // the marker only ever closes a run
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && marker |-> last_of_run)
    else $error("marker set before the end of the run");

  // fragments are video and carry the fu-a type in the indicator
  a_frag_indicator: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rhpp_pkg::KIND_FU_A) |->
      is_video && (fu_indicator[4:0] == rhpp_pkg::NAL_TYPE_FU_A))
    else $error("fragment descriptor with a bad indicator");

  // the queue never takes an item while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("command pushed into a full queue");

endmodule

>>> test/tb_rtp_h264_pcma_packetizer_unit.sv
// tb_rtp_h264_pcma_packetizer_unit: self-checking regression of the rtp h264 / pcma packetizer
// drives nal unit and audio frame items, predicts every packet descriptor in its own model
// depends on rhpp_pkg and rtp_h264_pcma_packetizer_unit
module tb_rtp_h264_pcma_packetizer_unit;

  localparam int PKT_BYTES    = 1400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PAUSE   = 4;
  localparam int TAIL_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 4000000;

  localparam logic       MODE_AUDIO     = 1'b0;
  localparam logic       MODE_VIDEO     = 1'b1;
  localparam logic       STATUS_OK      = 1'b0;
  localparam logic       STATUS_DROPPED = 1'b1;
  // index with no register behind it, writes there must change nothing
  localparam logic [1:0] CFG_UNUSED     = 2'd3;

  // one nal unit or audio frame as offered on the input side
  typedef struct {
    logic        mode;
    logic [31:0] ts;
    logic [15:0] size;
    logic [7:0]  nal;
  } unit_t;

  // one rtp packet descriptor as seen on the output side
  typedef struct {
    logic            is_video;
    logic            keyframe;
    logic [15:0]     seq;
    logic [31:0]     ts;
    logic            marker;
    rhpp_pkg::kind_t kind;
    logic [7:0]      fu_ind;
    logic [7:0]      fu_hdr;
    logic [15:0]     offset;
    logic [10:0]     length;
    logic            last;
    logic            status;
  } pkt_desc_t;

  typedef pkt_desc_t desc_q_t[$];

  // directed plan: either a register write or an item, the latter with an
  // optional typed-in expectation for single-descriptor cases
  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [10:0] reg_val;
    unit_t       u;
    bit          typed;
    pkt_desc_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [31:0] timestamp = '0;
  logic [15:0] unit_size = '0;
  logic [7:0]  nal_header = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_video;
  logic        keyframe;
  logic [15:0] seq_num;
  logic [31:0] ts_out;
  logic        marker;
  logic [1:0]  kind;
  logic [7:0]  fu_indicator;
  logic [7:0]  fu_header;
  logic [15:0] payload_offset;
  logic [10:0] payload_length;
  logic        last_of_run;
  logic        status;

  // packetizer state as the testbench sees it
  logic [15:0] next_video_seq = '0;
  logic [15:0] next_audio_seq = '0;
  logic [10:0] sps_bytes = '0;
  logic [10:0] pps_bytes = '0;

  // descriptors still owed by the block, oldest first
  pkt_desc_t   expected_pkts[$];
  pkt_desc_t   head;
  int          fault_count = 0;
  int          cycle_count = 0;

  // sender and receiver pacing
  bit          tx_at_fall = 1'b0;
  int          tx_calm_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          rx_hold_left = 0;
  int          rx_busy_left = 0;
  int          rx_calm_left = 0;
  int          rx_pick;

  rtp_h264_pcma_packetizer_unit #(
    .MAX_PACKET_BYTES(PKT_BYTES)
  ) dut (.*);

  always #6 clk = ~clk;

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rtp_h264_pcma_packetizer_unit regression: fail");
      $finish;
    end
  end

  function automatic pkt_desc_t desc(input logic vid, input logic kf,
                                     input logic [15:0] seq, input logic [31:0] ts,
                                     input logic mk, input rhpp_pkg::kind_t k,
                                     input logic [7:0] ind, input logic [7:0] hdr,
                                     input logic [15:0] off, input logic [10:0] len,
                                     input logic last, input logic st);
    pkt_desc_t d;
    d.is_video = vid;
    d.keyframe = kf;
    d.seq      = seq;
    d.ts       = ts;
    d.marker   = mk;
    d.kind     = k;
    d.fu_ind   = ind;
    d.fu_hdr   = hdr;
    d.offset   = off;
    d.length   = len;
    d.last     = last;
    d.status   = st;
    return d;
  endfunction

  // all descriptors for one accepted item; advances the sequence counters
  function automatic void expand_unit(input unit_t u, output desc_q_t run);
    logic [4:0] ntype;
    logic       kf;
    logic [7:0] ind;
    int         sz;
    int         single_max;
    int         frag;
    int         off;
    int         rem;
    int         n;
    int         len;
    run        = {};
    sz         = int'(u.size);
    single_max = PKT_BYTES - rhpp_pkg::RTP_HDR_BYTES;
    frag       = single_max - rhpp_pkg::FU_BYTES;
    if (u.mode == MODE_AUDIO) begin
      if (sz + rhpp_pkg::RTP_HDR_BYTES <= PKT_BYTES) begin
        run.push_back(desc(1'b0, 1'b1, next_audio_seq, u.ts, 1'b1, rhpp_pkg::KIND_SINGLE,
                           '0, '0, '0, 11'(sz), 1'b0, STATUS_OK));
        next_audio_seq++;
      end else begin
        // frame too long: dropped, sequence number not consumed
        run.push_back(desc(1'b0, 1'b1, next_audio_seq, u.ts, 1'b0, rhpp_pkg::KIND_SINGLE,
                           '0, '0, '0, '0, 1'b0, STATUS_DROPPED));
      end
    end else begin
      ntype = u.nal[4:0];
      kf    = (ntype == rhpp_pkg::NAL_TYPE_IDR);
      ind   = {1'b0, u.nal[6:5], rhpp_pkg::NAL_TYPE_FU_A};
      if (kf && sps_bytes != 0) begin
        // sps saturates so that it fits next to the playout-delay extension
        len = (sps_bytes > single_max - rhpp_pkg::EXT_BYTES) ?
              single_max - rhpp_pkg::EXT_BYTES : int'(sps_bytes);
        run.push_back(desc(1'b1, kf, next_video_seq, u.ts, 1'b0, rhpp_pkg::KIND_SPS,
                           '0, '0, '0, 11'(len), 1'b0, STATUS_OK));
        next_video_seq++;
      end
      if (kf && pps_bytes != 0) begin
        len = (pps_bytes > single_max) ? single_max : int'(pps_bytes);
        run.push_back(desc(1'b1, kf, next_video_seq, u.ts, 1'b0, rhpp_pkg::KIND_PPS,
                           '0, '0, '0, 11'(len), 1'b0, STATUS_OK));
        next_video_seq++;
      end
      if (sz <= single_max) begin
        run.push_back(desc(1'b1, kf, next_video_seq, u.ts, 1'b1, rhpp_pkg::KIND_SINGLE,
                           '0, '0, '0, 11'(sz), 1'b0, STATUS_OK));
        next_video_seq++;
      end else begin
        // first fragment skips the nal header byte
        run.push_back(desc(1'b1, kf, next_video_seq, u.ts, 1'b0, rhpp_pkg::KIND_FU_A, ind,
                           {3'b100, ntype}, 16'd1, 11'(frag), 1'b0, STATUS_OK));
        next_video_seq++;
        off = 1 + frag;
        rem = sz - 1 - frag;
        while (rem > 0 && run.size() < rhpp_pkg::MAX_RESULTS) begin
          n = (rem < frag) ? rem : frag;
          run.push_back(desc(1'b1, kf, next_video_seq, u.ts, n == rem,
                             rhpp_pkg::KIND_FU_A, ind, {1'b0, n == rem, 1'b0, ntype},
                             16'(off), 11'(n), 1'b0, STATUS_OK));
          next_video_seq++;
          off += n;
          rem -= n;
        end
      end
    end
    run[run.size() - 1].last = 1'b1;
  endfunction

  function automatic unit_t unit_of(input logic md, input logic [31:0] ts,
                                    input logic [15:0] size, input logic [7:0] nal);
    unit_t u;
    u.mode = md;
    u.ts   = ts;
    u.size = size;
    u.nal  = nal;
    return u;
  endfunction

  function automatic plan_row_t item_row(input unit_t u);
    plan_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.u       = u;
    r.typed   = 1'b0;
    r.want    = desc(1'b0, 1'b0, '0, '0, 1'b0, rhpp_pkg::KIND_SPS, '0, '0, '0, '0, 1'b0,
                     STATUS_OK);
    return r;
  endfunction

  function automatic plan_row_t typed_row(input unit_t u, input pkt_desc_t want);
    plan_row_t r;
    r       = item_row(u);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [10:0] val);
    plan_row_t r;
    r         = item_row(unit_of(MODE_AUDIO, '0, '0, '0));
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // mostly small units, some fragmented ones, a few up to the full size range
  function automatic unit_t random_unit();
    unit_t u;
    int    pick;
    u.mode = ($urandom_range(0, 2) != 0) ? MODE_VIDEO : MODE_AUDIO;
    u.ts   = $urandom;
    u.nal  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) u.nal[4:0] = rhpp_pkg::NAL_TYPE_IDR;
    pick = $urandom_range(0, 99);
    if (pick < 50) u.size = 16'($urandom_range(0, 1400));
    else if (pick < 60) u.size = 16'($urandom_range(1380, 1400));
    else if (pick < 82) u.size = 16'($urandom_range(1389, 6000));
    else if (pick < 95) u.size = 16'($urandom_range(0, 20000));
    else u.size = 16'($urandom_range(0, 65535));
    return u;
  endfunction

  // register lengths around the saturation points, zero and all ones
  function automatic logic [10:0] pick_len(input int top);
    case ($urandom_range(0, 5))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'(top);
      3: return 11'(top + 1);
      4: return 11'h7ff;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // input gap: mostly none or short, a few long, with calm stretches
  function automatic int tx_gap();
    int pick;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      tx_calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item and wait for it to be taken; returns at the next falling
  // edge with valid still high, so a following item can go straight on
  task automatic offer_unit(input unit_t u, input bit typed, input pkt_desc_t want);
    int      gap;
    desc_q_t run;
    gap = tx_gap();
    if (!tx_at_fall) @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= u.mode;
    timestamp  <= u.ts;
    unit_size  <= u.size;
    nal_header <= u.nal;
    tx_at_fall = 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_unit(u, run);
    if (typed) expected_pkts.push_back(want);
    else foreach (run[i]) expected_pkts.push_back(run[i]);
    @(negedge clk);
    tx_at_fall = 1'b1;
  endtask

  // drop valid if an item was just taken
  task automatic tx_idle();
    if (tx_at_fall) begin
      in_valid <= 1'b0;
      tx_at_fall = 1'b0;
    end
  endtask

  // wait until every owed descriptor has come out and the sequencer is done
  task automatic settle();
    tx_idle();
    while (expected_pkts.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rhpp_pkg::CFG_SPS_LENGTH) sps_bytes = val;
    else if (idx == rhpp_pkg::CFG_PPS_LENGTH) pps_bytes = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input longint unsigned exp,
                                      input longint unsigned act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      fault_count++;
    end
  endfunction

  // output side: every accepted descriptor against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pkts.size() == 0) begin
        $error("descriptor with seq_num 0x%0h arrived with nothing owed", seq_num);
        fault_count++;
      end else begin
        head = expected_pkts.pop_front();
        check_field("is_video", head.is_video, is_video);
        check_field("keyframe", head.keyframe, keyframe);
        check_field("seq_num", head.seq, seq_num);
        check_field("ts_out", head.ts, ts_out);
        check_field("marker", head.marker, marker);
        check_field("kind", head.kind, kind);
        check_field("fu_indicator", head.fu_ind, fu_indicator);
        check_field("fu_header", head.fu_hdr, fu_header);
        check_field("payload_offset", head.offset, payload_offset);
        check_field("payload_length", head.length, payload_length);
        check_field("last_of_run", head.last, last_of_run);
        check_field("status", head.status, status);
      end
    end
  end

  // output stall pacing: a long hold on request, otherwise short random
  // stalls, the odd long one, and calm stretches with no stall at all
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_busy_left > 0) begin
      rx_busy_left--;
      out_stall <= 1'b1;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
      out_stall <= 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 4) rx_calm_left = $urandom_range(20, 80);
      else if (rx_pick >= 70)
        rx_busy_left = (rx_pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_stall <= (rx_pick >= 70);
    end
  end

  initial begin
    plan_row_t plan[$];
    pkt_desc_t blank;
    blank = desc(1'b0, 1'b0, '0, '0, 1'b0, rhpp_pkg::KIND_SPS, '0, '0, '0, '0, 1'b0,
                 STATUS_OK);

    // right after reset: audio at the size limits, sequence numbers from zero
    plan.push_back(typed_row(unit_of(MODE_AUDIO, 32'h0000_0000, 16'd1, 8'h00),
      desc(1'b0, 1'b1, 16'd0, 32'h0000_0000, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd1, 1'b1, STATUS_OK)));
    plan.push_back(typed_row(unit_of(MODE_AUDIO, 32'hffff_ffff, 16'd1388, 8'hff),
      desc(1'b0, 1'b1, 16'd1, 32'hffff_ffff, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd1388, 1'b1, STATUS_OK)));
    // audio one byte too long: dropped, no sequence step
    plan.push_back(typed_row(unit_of(MODE_AUDIO, 32'h1234_5678, 16'd1389, 8'h80),
      desc(1'b0, 1'b1, 16'd2, 32'h1234_5678, 1'b0, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd0, 1'b1, STATUS_DROPPED)));
    plan.push_back(typed_row(unit_of(MODE_AUDIO, 32'h8000_0001, 16'hffff, 8'h00),
      desc(1'b0, 1'b1, 16'd2, 32'h8000_0001, 1'b0, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd0, 1'b1, STATUS_DROPPED)));
    // empty units, audio and video
    plan.push_back(typed_row(unit_of(MODE_AUDIO, 32'h0000_ffff, 16'd0, 8'h05),
      desc(1'b0, 1'b1, 16'd2, 32'h0000_ffff, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd0, 1'b1, STATUS_OK)));
    plan.push_back(typed_row(unit_of(MODE_VIDEO, 32'haaaa_5555, 16'd0, 8'h01),
      desc(1'b1, 1'b0, 16'd0, 32'haaaa_5555, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd0, 1'b1, STATUS_OK)));
    plan.push_back(typed_row(unit_of(MODE_VIDEO, 32'h5555_aaaa, 16'd1388, 8'h61),
      desc(1'b1, 1'b0, 16'd1, 32'h5555_aaaa, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd1388, 1'b1, STATUS_OK)));
    // keyframe while no parameter sets are stored
    plan.push_back(typed_row(unit_of(MODE_VIDEO, 32'h0f0f_f0f0, 16'd100, 8'h65),
      desc(1'b1, 1'b1, 16'd2, 32'h0f0f_f0f0, 1'b1, rhpp_pkg::KIND_SINGLE, '0, '0, '0,
           11'd100, 1'b1, STATUS_OK)));
    // fragmentation: just over the limit, exact two-fragment tail, largest unit
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0001, 16'd1389, 8'h41)));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h7fff_ffff, 16'd2773, 8'h3c)));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'hdead_beef, 16'hffff, 8'h9f)));
    // both parameter sets oversized and saturated, a write to no register
    plan.push_back(cfg_row(rhpp_pkg::CFG_SPS_LENGTH, 11'h7ff));
    plan.push_back(cfg_row(rhpp_pkg::CFG_PPS_LENGTH, 11'h7ff));
    plan.push_back(cfg_row(CFG_UNUSED, 11'h000));
    // keyframe at full size: the most descriptors one item can give
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'hcafe_f00d, 16'hffff, 8'h05)));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0002, 16'd1, 8'h25)));
    plan.push_back(item_row(unit_of(MODE_AUDIO, 32'h0000_0003, 16'd700, 8'h65)));
    // only one parameter set present at a time
    plan.push_back(cfg_row(rhpp_pkg::CFG_SPS_LENGTH, 11'd1));
    plan.push_back(cfg_row(rhpp_pkg::CFG_PPS_LENGTH, 11'd0));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0004, 16'd2000, 8'h65)));
    plan.push_back(cfg_row(rhpp_pkg::CFG_SPS_LENGTH, 11'd0));
    plan.push_back(cfg_row(rhpp_pkg::CFG_PPS_LENGTH, 11'd1388));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0005, 16'd1388, 8'h45)));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0006, 16'd5000, 8'h07)));
    // right at and just over the saturation points
    plan.push_back(cfg_row(rhpp_pkg::CFG_SPS_LENGTH, 11'd1380));
    plan.push_back(cfg_row(rhpp_pkg::CFG_PPS_LENGTH, 11'd1389));
    plan.push_back(item_row(unit_of(MODE_VIDEO, 32'h0000_0007, 16'd3000, 8'h85)));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_unit(plan[i].u, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own pair of lengths
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_reg(rhpp_pkg::CFG_SPS_LENGTH, pick_len(1380));
      write_reg(rhpp_pkg::CFG_PPS_LENGTH, pick_len(1388));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver holds off while items keep coming, so the block backs up
        if (p == 2 && i == 10) hold_requests++;
        // sender stops until the block has drained completely
        if (p == 5 && i == 30) settle();
        offer_unit(random_unit(), 1'b0, blank);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("rtp_h264_pcma_packetizer_unit regression: pass");
    end else begin
      $display("rtp_h264_pcma_packetizer_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rhpp_pkg.sv
rtl/core/rhpp_front.sv
rtl/core/rhpp_queue.sv
rtl/core/rhpp_back.sv
rtl/core/rtp_h264_pcma_packetizer_unit.sv
test/tb_rtp_h264_pcma_packetizer_unit.sv
